// ===== rtl/core/tole_pkg.sv =====
package tole_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_INS_POS  = 3'd1,
    CMD_INS_TIME = 3'd2,
    CMD_DROP     = 3'd3,
    CMD_READ     = 3'd4,
    CMD_FIND     = 3'd5,
    CMD_CLEAR    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } fsm_e;

  localparam logic [7:0] NULL_TYPE    = 8'hAA;
  localparam logic [7:0] NULL_VOICE   = 8'hFF;
  localparam logic [6:0] LIMIT_RESET  = 7'd64;

  typedef struct packed {
    logic [2:0]        command;
    logic [6:0]        position;
    logic [31:0]       time_stamp;
    logic [7:0]        event_type;
    logic [4:0]        channel;
    logic [6:0]        note_value;
    logic [6:0]        data_byte;
    logic signed [7:0] voice;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        found_position;
    logic [6:0]        list_length;
    logic [31:0]       time_stamp_out;
    logic [7:0]        event_type_out;
    logic [4:0]        channel_out;
    logic [6:0]        note_value_out;
    logic [6:0]        data_byte_out;
    logic signed [7:0] voice_out;
  } out_item_t;

  typedef struct packed {
    logic [31:0]       time_stamp;
    logic [7:0]        event_type;
    logic [4:0]        channel;
    logic [6:0]        note_value;
    logic [6:0]        data_byte;
    logic signed [7:0] voice;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic drop;
  } cell_ctl_t;

endpackage

// ===== rtl/core/tole_cell.sv =====
module tole_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic               clk,
  input  tole_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]      op_idx,
  input  tole_pkg::entry_t   new_entry,
  input  tole_pkg::entry_t   left_entry,
  input  tole_pkg::entry_t   right_entry,
  input  logic [31:0]        cmp_stamp,
  input  logic [6:0]         cmp_note,
  output tole_pkg::entry_t   entry_o,
  output tole_pkg::entry_t   rd_o,
  output logic               ge_o,
  output logic               eq_o
);
  import tole_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   hit;

  assign hit = (op_idx == MY_IDX);

  // Insert pushes the upper part of the row up by one; drop pulls it down.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (hit) begin
        entry_nxt = new_entry;
      end else if (MY_IDX > op_idx) begin
        entry_nxt = left_entry;
      end
    end else if (ctl.drop) begin
      if (MY_IDX >= op_idx) begin
        entry_nxt = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign rd_o    = hit ? entry_r : '0;
  assign ge_o    = (entry_r.time_stamp >= cmp_stamp);
  assign eq_o    = (entry_r.note_value == cmp_note);

endmodule

// ===== rtl/core/time_ordered_event_list_unit.sv =====
// Channel  | Ports                        | Handshake
// input    | start, busy, in_data         | taken when start is high and busy is low
// result   | out_valid, out_data          | shown for one cycle, cannot be held off
// config   | cfg_valid, cfg_ready, cfg_data | written when valid and ready are high
//
// In the accept cycle each cell compares its entry with the new item and the
// flags are registered; in the next cycle the cell row shifts or holds and the
// result is registered. The result strobe comes in the cycle after that, while
// the next item may already be taken.
// Reset clears the entry count, the limit (to 64) and the control state.
module time_ordered_event_list_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tole_pkg::in_item_t  in_data,
  output logic                out_valid,
  output tole_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import tole_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = (CW > 7) ? CW : 7;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_ENTRIES);

  fsm_e      state_r, state_nxt;
  in_item_t  in_r;
  logic [MAX_ENTRIES-1:0] ge_r, eq_r, ge_c, eq_c;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [6:0]    limit_r;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      accept;

  entry_t    cell_q   [MAX_ENTRIES];
  entry_t    cell_rd  [MAX_ENTRIES];
  entry_t    new_entry;
  entry_t    rd_entry;
  cell_ctl_t ctl;
  logic [IW-1:0] op_idx;

  logic [WW-1:0] cnt_w, pos_w, limit_w, eff_limit, first_ge, last_eq, ins_w;
  logic          full, any_eq;

  assign accept    = start && !busy;
  assign busy      = (state_r == S_APPLY);
  assign cfg_ready = 1'b1;

  assign new_entry.time_stamp = in_r.time_stamp;
  assign new_entry.event_type = in_r.event_type;
  assign new_entry.channel    = in_r.channel;
  assign new_entry.note_value = in_r.note_value;
  assign new_entry.data_byte  = in_r.data_byte;
  assign new_entry.voice      = in_r.voice;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    tole_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .op_idx      (op_idx),
      .new_entry   (new_entry),
      .left_entry  (cell_q[(g == 0) ? 0 : g - 1]),
      .right_entry (cell_q[(g == MAX_ENTRIES - 1) ? g : g + 1]),
      .cmp_stamp   (in_data.time_stamp),
      .cmp_note    (in_data.note_value),
      .entry_o     (cell_q[g]),
      .rd_o        (cell_rd[g]),
      .ge_o        (ge_c[g]),
      .eq_o        (eq_c[g])
    );
  end

  assign cnt_w     = WW'(cnt_r);
  assign pos_w     = WW'(in_r.position);
  assign limit_w   = WW'(limit_r);
  assign eff_limit = (limit_w < MAX_W) ? limit_w : MAX_W;
  assign full      = (cnt_w >= eff_limit);

  // Only cells below the count hold live entries.
  always_comb begin
    first_ge = cnt_w;
    last_eq  = '0;
    any_eq   = 1'b0;
    rd_entry = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (ge_r[i] && (WW'(i) < cnt_w)) begin
        first_ge = WW'(i);
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (eq_r[i] && (WW'(i) < cnt_w)) begin
        last_eq = WW'(i);
        any_eq  = 1'b1;
      end
      rd_entry = rd_entry | cell_rd[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    cnt_nxt       = cnt_r;
    ctl           = '0;
    ins_w         = '0;
    op_idx        = pos_w[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        case (cmd_e'(in_r.command))
          CMD_APPEND, CMD_INS_POS, CMD_INS_TIME: begin
            if (cmd_e'(in_r.command) == CMD_APPEND) begin
              ins_w = cnt_w;
            end else if (cmd_e'(in_r.command) == CMD_INS_POS) begin
              ins_w = pos_w;
            end else begin
              ins_w = first_ge;
            end
            if (full) begin
              out_nxt.status = ST_FULL;
            end else if (ins_w > cnt_w) begin
              out_nxt.status = ST_RANGE;
            end else begin
              ctl.ins                = 1'b1;
              op_idx                 = ins_w[IW-1:0];
              cnt_nxt                = cnt_r + 1'b1;
              out_nxt.found_position = ins_w[5:0];
            end
          end
          CMD_DROP: begin
            if (pos_w >= cnt_w) begin
              out_nxt.status = ST_RANGE;
            end else begin
              ctl.drop = 1'b1;
              cnt_nxt  = cnt_r - 1'b1;
            end
          end
          CMD_READ: begin
            if (pos_w >= cnt_w) begin
              out_nxt.status         = ST_RANGE;
              out_nxt.event_type_out = NULL_TYPE;
              out_nxt.voice_out      = NULL_VOICE;
            end else begin
              out_nxt.time_stamp_out = rd_entry.time_stamp;
              out_nxt.event_type_out = rd_entry.event_type;
              out_nxt.channel_out    = rd_entry.channel;
              out_nxt.note_value_out = rd_entry.note_value;
              out_nxt.data_byte_out  = rd_entry.data_byte;
              out_nxt.voice_out      = rd_entry.voice;
            end
          end
          CMD_FIND: begin
            if (any_eq) begin
              out_nxt.found_position = last_eq[5:0];
            end else begin
              out_nxt.status = ST_NOT_FOUND;
            end
          end
          CMD_CLEAR: begin
            cnt_nxt = '0;
          end
          default: begin
          end
        endcase
        out_nxt.list_length = 7'(WW'(cnt_nxt));
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      in_r <= in_data;
      ge_r <= ge_c;
      eq_r <= eq_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(cnt_r) <= MAX_W)
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not make the unit busy");

  a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_APPLY))
    else $error("result strobe without an update cycle");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && cmd_e'(in_r.command) == CMD_CLEAR) |=> (cnt_r == '0))
    else $error("clear left entries in the list");

  a_no_shift_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.ins) |-> !full)
    else $error("insert into a full list");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import tole_pkg::*;

  localparam int DEPTH = 64;
  localparam int PHASES = 11;
  localparam int PER_PHASE = 84;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct {
    bit         is_cfg;
    logic [6:0] limit;
    in_item_t   cmd;
    bit         typed;
    out_item_t  want;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_data = '0;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  // Shadow copy of the event list and its length limit.
  entry_t      stored [DEPTH];
  int unsigned n_entries = 0;
  logic [6:0]  lim_now = LIMIT_RESET;

  out_item_t replies_due[$];
  plan_row_t plan[$];
  int        errors = 0;
  int        n_results = 0;
  bit        gaps_on = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  time_ordered_event_list_unit #(
    .MAX_ENTRIES(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  task automatic flag(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag($sformatf("result %0d %s: got %0h, expected %0h", n_results, name, got, want));
  endtask

  function automatic void place_entry(int unsigned slot, in_item_t it);
    for (int i = n_entries; i > int'(slot); i--) stored[i] = stored[i - 1];
    stored[slot].time_stamp = it.time_stamp;
    stored[slot].event_type = it.event_type;
    stored[slot].channel    = it.channel;
    stored[slot].note_value = it.note_value;
    stored[slot].data_byte  = it.data_byte;
    stored[slot].voice      = it.voice;
    n_entries++;
  endfunction

  // Applies one command to the shadow list and returns the reply it must produce.
  function automatic out_item_t list_reply(in_item_t it);
    out_item_t   rep;
    int unsigned cap;
    int unsigned slot;
    bit          full;
    rep = '0;
    cap = (lim_now < DEPTH) ? lim_now : DEPTH;
    full = (n_entries >= cap);
    case (it.command)
      CMD_APPEND: begin
        if (full) begin
          rep.status = ST_FULL;
        end else begin
          rep.found_position = 6'(n_entries);
          place_entry(n_entries, it);
        end
      end
      CMD_INS_POS: begin
        if (full) begin
          rep.status = ST_FULL;
        end else if (it.position > n_entries) begin
          rep.status = ST_RANGE;
        end else begin
          rep.found_position = 6'(it.position);
          place_entry(it.position, it);
        end
      end
      CMD_INS_TIME: begin
        if (full) begin
          rep.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < n_entries && stored[slot].time_stamp < it.time_stamp) slot++;
          rep.found_position = 6'(slot);
          place_entry(slot, it);
        end
      end
      CMD_DROP: begin
        if (it.position >= n_entries) begin
          rep.status = ST_RANGE;
        end else begin
          for (int unsigned i = it.position; i + 1 < n_entries; i++) stored[i] = stored[i + 1];
          n_entries--;
        end
      end
      CMD_READ: begin
        if (it.position >= n_entries) begin
          rep.status = ST_RANGE;
          rep.event_type_out = NULL_TYPE;
          rep.voice_out = NULL_VOICE;
        end else begin
          rep.time_stamp_out = stored[it.position].time_stamp;
          rep.event_type_out = stored[it.position].event_type;
          rep.channel_out    = stored[it.position].channel;
          rep.note_value_out = stored[it.position].note_value;
          rep.data_byte_out  = stored[it.position].data_byte;
          rep.voice_out      = stored[it.position].voice;
        end
      end
      CMD_FIND: begin
        rep.status = ST_NOT_FOUND;
        for (int unsigned i = 0; i < n_entries; i++) begin
          if (stored[i].note_value == it.note_value) begin
            rep.status = ST_DONE;
            rep.found_position = 6'(i);
          end
        end
      end
      CMD_CLEAR: n_entries = 0;
      default: ;
    endcase
    rep.list_length = 7'(n_entries);
    return rep;
  endfunction

  function automatic in_item_t cmd_item(logic [2:0] cmd, logic [6:0] pos, logic [31:0] ts,
                                        logic [7:0] etype, logic [4:0] ch, logic [6:0] val,
                                        logic [6:0] data, logic signed [7:0] voice);
    in_item_t it;
    it.command    = cmd;
    it.position   = pos;
    it.time_stamp = ts;
    it.event_type = etype;
    it.channel    = ch;
    it.note_value = val;
    it.data_byte  = data;
    it.voice      = voice;
    return it;
  endfunction

  function automatic out_item_t plain_reply(logic [1:0] st, logic [5:0] fp, logic [6:0] len);
    out_item_t rep;
    rep = '0;
    rep.status = st;
    rep.found_position = fp;
    rep.list_length = len;
    return rep;
  endfunction

  function automatic out_item_t null_read(logic [6:0] len);
    out_item_t rep;
    rep = plain_reply(ST_RANGE, 6'd0, len);
    rep.event_type_out = NULL_TYPE;
    rep.voice_out = NULL_VOICE;
    return rep;
  endfunction

  function automatic void put_cmd(in_item_t it);
    plan_row_t row;
    row = '{is_cfg: 1'b0, limit: '0, cmd: it, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void put_checked(in_item_t it, out_item_t want);
    plan_row_t row;
    row = '{is_cfg: 1'b0, limit: '0, cmd: it, typed: 1'b1, want: want};
    plan.push_back(row);
  endfunction

  function automatic void put_limit(logic [6:0] v);
    plan_row_t row;
    row = '{is_cfg: 1'b1, limit: v, cmd: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  // Random command; grow is the percentage of inserts, which sets whether the list
  // tends to fill up or drain.
  function automatic in_item_t random_item(int unsigned grow);
    in_item_t    it;
    int unsigned pick;
    it.event_type = 8'($urandom);
    it.channel    = 5'($urandom);
    it.data_byte  = 7'($urandom);
    it.voice      = 8'($urandom);
    case ($urandom_range(0, 3))
      0: it.time_stamp = $urandom;
      1: it.time_stamp = $urandom_range(0, 15);
      2: it.time_stamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: it.time_stamp = (n_entries > 0) ?
          stored[$urandom_range(0, n_entries - 1)].time_stamp : $urandom;
    endcase
    if (n_entries > 0 && $urandom_range(0, 1))
      it.note_value = stored[$urandom_range(0, n_entries - 1)].note_value;
    else
      it.note_value = 7'($urandom);
    if ($urandom_range(0, 99) < 80)
      it.position = 7'($urandom_range(0, n_entries + 1));
    else
      it.position = 7'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < grow) begin
      case ($urandom_range(0, 2))
        0: it.command = CMD_APPEND;
        1: it.command = CMD_INS_POS;
        default: it.command = CMD_INS_TIME;
      endcase
    end else if (pick < 96) begin
      case ($urandom_range(0, 2))
        0: it.command = CMD_DROP;
        1: it.command = CMD_READ;
        default: it.command = CMD_FIND;
      endcase
    end else if (pick < 98) begin
      it.command = CMD_CLEAR;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // with start still high so that a following item can go out back to back.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t pred;
    if (gaps_on && $urandom_range(0, 99) < 22) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_data = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pred = list_reply(it);
    replies_due.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    start = 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (gaps_on && $urandom_range(0, 99) < 22) repeat ($urandom_range(1, 6)) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    lim_now = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        flag($sformatf("result %0d arrived with no command outstanding", n_results));
      end else begin
        want = replies_due.pop_front();
        check_field("status", out_data.status, want.status);
        check_field("found_position", out_data.found_position, want.found_position);
        check_field("list_length", out_data.list_length, want.list_length);
        check_field("time_stamp_out", out_data.time_stamp_out, want.time_stamp_out);
        check_field("event_type_out", out_data.event_type_out, want.event_type_out);
        check_field("channel_out", out_data.channel_out, want.channel_out);
        check_field("note_value_out", out_data.note_value_out, want.note_value_out);
        check_field("data_byte_out", out_data.data_byte_out, want.data_byte_out);
        check_field("voice_out", 8'(out_data.voice_out), 8'(want.voice_out));
      end
      n_results++;
    end
  end

  initial begin
    #(300000 * 12);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [6:0]  lim_tab [PHASES];
    int unsigned grow_tab [PHASES];
    logic [6:0]  v;
    int          guard;
    lim_tab  = '{7'd64, 7'd127, 7'd2, 7'd64, 7'd1, 7'd100, 7'd64, 7'd0, 7'd33, 7'd64, 7'd64};
    grow_tab = '{75, 45, 60, 20, 50, 70, 30, 60, 55, 40, 25};

    // Empty list right after reset.
    put_checked(cmd_item(CMD_READ, 7'd0, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0), null_read(7'd0));
    put_checked(cmd_item(CMD_DROP, 7'd0, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0),
                plain_reply(ST_RANGE, 6'd0, 7'd0));
    put_checked(cmd_item(CMD_FIND, 7'd0, 32'd0, 8'd0, 5'd0, 7'd5, 7'd0, 8'sd0),
                plain_reply(ST_NOT_FOUND, 6'd0, 7'd0));
    put_checked(cmd_item(CMD_INS_POS, 7'd1, 32'd7, 8'd1, 5'd1, 7'd1, 7'd1, 8'sd1),
                plain_reply(ST_RANGE, 6'd0, 7'd0));
    // Field extremes, and a tie on the timestamp that must go in front.
    put_checked(cmd_item(CMD_APPEND, 7'd0, 32'hFFFF_FFFF, 8'hFF, 5'h1F, 7'h7F, 7'h7F, 8'sd127),
                plain_reply(ST_DONE, 6'd0, 7'd1));
    put_checked(cmd_item(CMD_INS_TIME, 7'd0, 32'd0, 8'h00, 5'h00, 7'h00, 7'h00, -8'sd128),
                plain_reply(ST_DONE, 6'd0, 7'd2));
    put_checked(cmd_item(CMD_INS_TIME, 7'd0, 32'd0, 8'h5A, 5'h10, 7'h7F, 7'h33, -8'sd1),
                plain_reply(ST_DONE, 6'd0, 7'd3));
    put_cmd(cmd_item(CMD_INS_POS, 7'd3, 32'd100, 8'h90, 5'd9, 7'd60, 7'd100, -8'sd1));
    put_cmd(cmd_item(CMD_INS_POS, 7'd1, 32'd50, 8'h80, 5'd3, 7'h7F, 7'd64, 8'sd12));
    put_cmd(cmd_item(CMD_INS_TIME, 7'd0, 32'h8000_0000, 8'h91, 5'd16, 7'd42, 7'd1, 8'sd3));
    put_cmd(cmd_item(CMD_READ, 7'd0, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0));
    put_cmd(cmd_item(CMD_READ, 7'd5, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0));
    put_checked(cmd_item(CMD_READ, 7'd127, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0), null_read(7'd6));
    put_cmd(cmd_item(CMD_FIND, 7'd0, 32'd0, 8'd0, 5'd0, 7'h7F, 7'd0, 8'sd0));
    put_checked(cmd_item(CMD_DROP, 7'd127, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0),
                plain_reply(ST_RANGE, 6'd0, 7'd6));
    put_cmd(cmd_item(CMD_DROP, 7'd0, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0));
    put_cmd(cmd_item(CMD_DROP, 7'd4, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0));
    put_cmd(cmd_item(CMD_UNUSED, 7'd2, 32'd9, 8'd9, 5'd9, 7'd9, 7'd9, 8'sd9));
    put_checked(cmd_item(CMD_CLEAR, 7'd0, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0),
                plain_reply(ST_DONE, 6'd0, 7'd0));
    // A zero limit refuses every insert; fullness wins over a bad position.
    put_limit(7'd0);
    put_checked(cmd_item(CMD_APPEND, 7'd0, 32'd1, 8'd1, 5'd1, 7'd1, 7'd1, 8'sd1),
                plain_reply(ST_FULL, 6'd0, 7'd0));
    put_checked(cmd_item(CMD_INS_POS, 7'd5, 32'd1, 8'd1, 5'd1, 7'd1, 7'd1, 8'sd1),
                plain_reply(ST_FULL, 6'd0, 7'd0));
    put_limit(7'd1);
    put_checked(cmd_item(CMD_APPEND, 7'd0, 32'd20, 8'h3C, 5'd2, 7'd64, 7'd90, -8'sd1),
                plain_reply(ST_DONE, 6'd0, 7'd1));
    put_checked(cmd_item(CMD_INS_TIME, 7'd0, 32'd5, 8'd1, 5'd1, 7'd1, 7'd1, 8'sd1),
                plain_reply(ST_FULL, 6'd0, 7'd1));
    put_checked(cmd_item(CMD_INS_POS, 7'd9, 32'd5, 8'd1, 5'd1, 7'd1, 7'd1, 8'sd1),
                plain_reply(ST_FULL, 6'd0, 7'd1));
    put_cmd(cmd_item(CMD_READ, 7'd0, 32'd0, 8'd0, 5'd0, 7'd0, 7'd0, 8'sd0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_limit(plan[k].limit);
      else send_item(plan[k].cmd, plan[k].typed, plan[k].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      v = lim_tab[p];
      if (p == 9) v = 7'($urandom_range(1, DEPTH));
      // One phase runs with no gaps at all, back to back.
      gaps_on = (p != 6);
      write_limit(v);
      for (int n = 0; n < PER_PHASE; n++) send_item(random_item(grow_tab[p]), 1'b0, '0);
    end

    start = 1'b0;
    guard = 0;
    while (replies_due.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (replies_due.size() != 0)
      flag($sformatf("%0d results never arrived", replies_due.size()));
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tole_pkg.sv
rtl/core/tole_cell.sv
rtl/core/time_ordered_event_list_unit.sv
dv/tb.sv
